[rtl/mrt_pkg.sv]
package mrt_pkg;

    localparam int ADDR_BITS      = 48;
    localparam int LEN_BITS       = 48;
    localparam int PROT_IN_BITS   = 8;
    localparam int PROT_BITS      = 3;
    localparam int HANDLE_BITS    = 16;
    localparam int SLOT_OUT_BITS  = 4;
    localparam int STATUS_BITS    = 2;
    localparam int CMD_BITS       = 3;
    localparam int CFG_INDEX_BITS = 1;

    localparam int DEF_TABLE_SLOTS = 16;
    localparam int DEF_PAGE_SHIFT  = 12;

    localparam logic [CMD_BITS-1:0] CMD_LOOKUP  = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_MAP     = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_UNMAP   = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_PROTECT = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 3'd4;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_INVAL = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_NOMEM = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_BASE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_USER_TOP = 1'd1;

    localparam logic [ADDR_BITS-1:0] MAP_BASE_RESET = 48'h0000_1000_0000;
    localparam logic [ADDR_BITS-1:0] USER_TOP_RESET = 48'h8000_0000_0000;

endpackage

[rtl/mrt_if.sv]
interface mrt_req_if;
    import mrt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_BITS-1:0]     cmd;
    logic [ADDR_BITS-1:0]    address;
    logic [LEN_BITS-1:0]     length;
    logic [PROT_IN_BITS-1:0] prot_bits;
    logic                    shared_map;
    logic                    private_map;
    logic                    fixed_map;
    logic                    file_backed;
    logic [HANDLE_BITS-1:0]  backing_handle;
    logic [ADDR_BITS-1:0]    file_offset;

    modport source (
        output valid, cmd, address, length, prot_bits, shared_map, private_map,
               fixed_map, file_backed, backing_handle, file_offset,
        input  ready
    );

    modport sink (
        input  valid, cmd, address, length, prot_bits, shared_map, private_map,
               fixed_map, file_backed, backing_handle, file_offset,
        output ready
    );
endinterface

interface mrt_rsp_if;
    import mrt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_BITS-1:0]   status;
    logic [ADDR_BITS-1:0]     mapped_start;
    logic                     hit;
    logic [SLOT_OUT_BITS-1:0] region_slot;
    logic [PROT_BITS-1:0]     region_prot;
    logic                     region_backed;
    logic [HANDLE_BITS-1:0]   region_handle;
    logic [ADDR_BITS-1:0]     page_file_offset;

    modport source (
        output valid, status, mapped_start, hit, region_slot, region_prot,
               region_backed, region_handle, page_file_offset,
        input  ready
    );

    modport sink (
        input  valid, status, mapped_start, hit, region_slot, region_prot,
               region_backed, region_handle, page_file_offset,
        output ready
    );
endinterface

[rtl/mrt_ram.sv]
module mrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/mapped_region_table.sv]
// Channel   Dir  Transfer when          Payload
// request   in   valid & ready          cmd, address, length, prot, flags, handle, offset
// response  out  valid & ready          status, mapped_start, lookup fields
// cfg       in   cfg_we                 cfg_index, cfg_data (no wait)
//
// One command at a time. Each pass over the slot memory reads each slot, then
// evaluates it and writes it back. Lookup makes one pass, map one pass and then
// the insert, unmap and protect a check pass and then a modify pass. A split
// adds a tail write. Clear and commands rejected at the check skip the passes.
// Reset empties the table at once through per-slot valid flops; no clearing pass.
// A finished result waits in the output register while the next command is taken.
module mapped_region_table #(
    parameter int TABLE_SLOTS = mrt_pkg::DEF_TABLE_SLOTS,
    parameter int PAGE_SHIFT  = mrt_pkg::DEF_PAGE_SHIFT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    mrt_req_if.sink                             request,
    mrt_rsp_if.source                           response,
    input  logic                                cfg_we,
    input  logic [mrt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mrt_pkg::ADDR_BITS-1:0]       cfg_data
);
    import mrt_pkg::*;

    localparam int PW = ADDR_BITS - PAGE_SHIFT;
    localparam int EW = PW + 1;
    localparam int IW = $clog2(TABLE_SLOTS);

    typedef struct packed {
        logic [PW-1:0]          start;
        logic [PW-1:0]          count;
        logic [PROT_BITS-1:0]   prot;
        logic                   shared;
        logic                   backed;
        logic [HANDLE_BITS-1:0] handle;
        logic [ADDR_BITS-1:0]   offset;
    } slot_rec_t;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_EV   = 4'd4;
    localparam logic [3:0] S_TAIL = 4'd5;
    localparam logic [3:0] S_END  = 4'd6;
    localparam logic [3:0] S_INS  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    localparam logic [2:0] P_LOOK = 3'd0;
    localparam logic [2:0] P_COV  = 3'd1;
    localparam logic [2:0] P_OVL  = 3'd2;
    localparam logic [2:0] P_CUT  = 3'd3;
    localparam logic [2:0] P_PROT = 3'd4;

    logic [3:0]             state_reg, state_next;
    logic [2:0]             pass_reg;
    logic [IW-1:0]          idx_reg;
    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [ADDR_BITS-1:0]   map_base_reg, user_top_reg, next_free_reg;
    logic                   out_valid_reg;

    logic [CMD_BITS-1:0]     cmd_reg;
    logic [ADDR_BITS-1:0]    addr_reg;
    logic [LEN_BITS-1:0]     len_reg;
    logic [PROT_IN_BITS-1:0] prot_reg;
    logic                    shared_reg, private_reg, fixed_reg, backed_reg;
    logic [HANDLE_BITS-1:0]  handle_reg;
    logic [ADDR_BITS-1:0]    foff_reg;
    logic [PW-1:0]           sp_reg;
    logic [EW-1:0]           np_reg, ep_reg, sum_reg;
    logic                    ovl_reg;

    logic [STATUS_BITS-1:0]   st_reg;
    logic [ADDR_BITS-1:0]     start_res_reg;
    logic                     hit_res_reg;
    logic [SLOT_OUT_BITS-1:0] slot_res_reg;
    logic [PROT_BITS-1:0]     prot_res_reg;
    logic                     backed_res_reg;
    logic [HANDLE_BITS-1:0]   handle_res_reg;
    logic [ADDR_BITS-1:0]     pfo_res_reg;

    logic [STATUS_BITS-1:0]   out_status_reg;
    logic [ADDR_BITS-1:0]     out_start_reg;
    logic                     out_hit_reg;
    logic [SLOT_OUT_BITS-1:0] out_slot_reg;
    logic [PROT_BITS-1:0]     out_prot_reg;
    logic                     out_backed_reg;
    logic [HANDLE_BITS-1:0]   out_handle_reg;
    logic [ADDR_BITS-1:0]     out_pfo_reg;

    logic                    ram_we, ram_re;
    logic [IW-1:0]           ram_waddr;
    slot_rec_t               ram_wdata, rec;
    logic [$bits(slot_rec_t)-1:0] ram_rdata;

    logic [EW-1:0]        rs, re_pg, spx, us, ue, ep_comb, top_pg;
    logic                 slot_v, ovl, hit_here, full_cut, front_cut, back_cut, last;
    logic [ADDR_BITS-1:0] off_front, pfo_here;
    slot_rec_t            rec_front, rec_head, rec_prot, rec_new;
    logic                 free_any;
    logic [IW-1:0]        free_idx;
    logic                 arg_bad_map, arg_bad_unmap, arg_bad_prot, len_zero, addr_unal;
    logic                 out_load;

    mrt_ram #(
        .WIDTH ($bits(slot_rec_t)),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rec = slot_rec_t'(ram_rdata);

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        rs        = {1'b0, rec.start};
        re_pg     = rs + {1'b0, rec.count};
        spx       = {1'b0, sp_reg};
        slot_v    = valid_reg[idx_reg];
        ovl       = slot_v && (spx < re_pg) && (ep_reg > rs);
        hit_here  = slot_v && (spx >= rs) && (spx < re_pg);
        us        = (spx > rs) ? spx : rs;
        ue        = (ep_reg < re_pg) ? ep_reg : re_pg;
        full_cut  = (us == rs) && (ue == re_pg);
        front_cut = (us == rs) && (ue != re_pg);
        back_cut  = (us != rs) && (ue == re_pg);
        off_front = rec.offset + (ADDR_BITS'(ue - rs) << PAGE_SHIFT);
        pfo_here  = rec.offset + (ADDR_BITS'(spx - rs) << PAGE_SHIFT);
        last      = (idx_reg == IW'(TABLE_SLOTS - 1));

        rec_front        = rec;
        rec_front.start  = PW'(ue);
        rec_front.count  = PW'(re_pg - ue);
        rec_front.offset = off_front;
        rec_head         = rec;
        rec_head.count   = PW'(us - rs);
        rec_prot         = rec;
        rec_prot.prot    = prot_reg[PROT_BITS-1:0];
        rec_new.start    = sp_reg;
        rec_new.count    = PW'(np_reg);
        rec_new.prot     = prot_reg[PROT_BITS-1:0];
        rec_new.shared   = shared_reg;
        rec_new.backed   = backed_reg;
        rec_new.handle   = backed_reg ? handle_reg : '0;
        rec_new.offset   = foff_reg;

        ep_comb = spx + np_reg;
        top_pg  = {1'b0, user_top_reg[ADDR_BITS-1:PAGE_SHIFT]};

        len_zero      = (len_reg == '0);
        addr_unal     = (addr_reg[PAGE_SHIFT-1:0] != '0);
        arg_bad_map   = len_zero || (prot_reg[PROT_IN_BITS-1:PROT_BITS] != '0)
                        || (shared_reg == private_reg)
                        || (foff_reg[PAGE_SHIFT-1:0] != '0) || (fixed_reg && addr_unal);
        arg_bad_unmap = addr_unal || len_zero;
        arg_bad_prot  = (prot_reg[PROT_IN_BITS-1:PROT_BITS] != '0) || addr_unal || len_zero;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = rec;
        ram_re    = (state_reg == S_RD);
        if (state_reg == S_EV && ovl)
        begin
            if (pass_reg == P_CUT && !full_cut)
            begin
                ram_we    = 1'b1;
                ram_wdata = front_cut ? rec_front : rec_head;
            end
            else if (pass_reg == P_PROT)
            begin
                ram_we    = 1'b1;
                ram_wdata = rec_prot;
            end
        end
        else if (state_reg == S_TAIL && free_any)
        begin
            ram_we    = 1'b1;
            ram_waddr = free_idx;
            ram_wdata = rec_front;
        end
        else if (state_reg == S_INS && free_any)
        begin
            ram_we    = 1'b1;
            ram_waddr = free_idx;
            ram_wdata = rec_new;
        end
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || response.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (request.valid) state_next = S_PREP;
            S_PREP: state_next = S_CHK;
            S_CHK:
            begin
                unique case (cmd_reg)
                    CMD_LOOKUP:  state_next = S_RD;
                    CMD_MAP:     state_next = (arg_bad_map || ep_comb > top_pg) ? S_DONE : S_RD;
                    CMD_UNMAP:   state_next = arg_bad_unmap ? S_DONE : S_RD;
                    CMD_PROTECT: state_next = arg_bad_prot ? S_DONE : S_RD;
                    default:     state_next = S_DONE;
                endcase
            end
            S_RD:   state_next = S_EV;
            S_EV:
            begin
                if (pass_reg == P_CUT && ovl && !full_cut && !front_cut && !back_cut)
                    state_next = S_TAIL;
                else
                    state_next = last ? S_END : S_RD;
            end
            S_TAIL: state_next = last ? S_END : S_RD;
            S_END:
            begin
                unique case (pass_reg)
                    P_COV:   state_next = (sum_reg != np_reg) ? S_DONE : S_RD;
                    P_OVL:   state_next = ovl_reg ? S_DONE : S_INS;
                    P_CUT:   state_next = (cmd_reg == CMD_MAP) ? S_INS : S_DONE;
                    default: state_next = S_DONE;
                endcase
            end
            S_INS:  state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign request.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= P_LOOK;
            idx_reg       <= '0;
            valid_reg     <= '0;
            map_base_reg  <= MAP_BASE_RESET;
            user_top_reg  <= USER_TOP_RESET;
            next_free_reg <= MAP_BASE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAP_BASE: map_base_reg <= cfg_data;
                    CFG_USER_TOP: user_top_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (response.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CHK:
                begin
                    idx_reg <= '0;
                    if (cmd_reg == CMD_CLEAR)
                    begin
                        valid_reg     <= '0;
                        next_free_reg <= map_base_reg;
                    end
                    unique case (cmd_reg)
                        CMD_MAP:  pass_reg <= fixed_reg ? P_CUT : P_OVL;
                        CMD_UNMAP, CMD_PROTECT: pass_reg <= P_COV;
                        default:  pass_reg <= P_LOOK;
                    endcase
                end
                S_EV:
                begin
                    if (pass_reg == P_CUT && ovl && full_cut)
                        valid_reg[idx_reg] <= 1'b0;
                    if (state_next == S_RD)
                        idx_reg <= idx_reg + 1'b1;
                end
                S_TAIL:
                begin
                    if (free_any)
                        valid_reg[free_idx] <= 1'b1;
                    if (!last)
                        idx_reg <= idx_reg + 1'b1;
                end
                S_END:
                begin
                    idx_reg <= '0;
                    if (pass_reg == P_COV)
                        pass_reg <= (cmd_reg == CMD_UNMAP) ? P_CUT : P_PROT;
                end
                S_INS:
                begin
                    if (free_any)
                    begin
                        valid_reg[free_idx] <= 1'b1;
                        if ((ADDR_BITS'(ep_reg) << PAGE_SHIFT) > next_free_reg)
                            next_free_reg <= ADDR_BITS'(ep_reg) << PAGE_SHIFT;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_reg        <= request.cmd;
                addr_reg       <= request.address;
                len_reg        <= request.length;
                prot_reg       <= request.prot_bits;
                shared_reg     <= request.shared_map;
                private_reg    <= request.private_map;
                fixed_reg      <= request.fixed_map;
                backed_reg     <= request.file_backed;
                handle_reg     <= request.backing_handle;
                foff_reg       <= request.file_offset;
                st_reg         <= STATUS_OK;
                start_res_reg  <= '0;
                hit_res_reg    <= 1'b0;
                slot_res_reg   <= '0;
                prot_res_reg   <= '0;
                backed_res_reg <= 1'b0;
                handle_res_reg <= '0;
                pfo_res_reg    <= '0;
            end
            S_PREP:
            begin
                np_reg <= EW'(len_reg >> PAGE_SHIFT) + EW'(len_reg[PAGE_SHIFT-1:0] != '0);
                sp_reg <= (cmd_reg == CMD_MAP && !fixed_reg)
                          ? next_free_reg[ADDR_BITS-1:PAGE_SHIFT]
                          : addr_reg[ADDR_BITS-1:PAGE_SHIFT];
            end
            S_CHK:
            begin
                ep_reg  <= ep_comb;
                sum_reg <= '0;
                ovl_reg <= 1'b0;
                unique case (cmd_reg)
                    CMD_LOOKUP, CMD_CLEAR: st_reg <= STATUS_OK;
                    CMD_MAP:
                    begin
                        if (arg_bad_map)
                            st_reg <= STATUS_INVAL;
                        else if (ep_comb > top_pg)
                            st_reg <= STATUS_NOMEM;
                    end
                    CMD_UNMAP:   if (arg_bad_unmap) st_reg <= STATUS_INVAL;
                    CMD_PROTECT: if (arg_bad_prot) st_reg <= STATUS_INVAL;
                    default:     st_reg <= STATUS_INVAL;
                endcase
            end
            S_EV:
            begin
                if (pass_reg == P_LOOK && hit_here && !hit_res_reg)
                begin
                    hit_res_reg    <= 1'b1;
                    slot_res_reg   <= SLOT_OUT_BITS'(idx_reg);
                    prot_res_reg   <= rec.prot;
                    backed_res_reg <= rec.backed;
                    handle_res_reg <= rec.handle;
                    pfo_res_reg    <= pfo_here;
                end
                if (pass_reg == P_COV && ovl)
                    sum_reg <= sum_reg + (ue - us);
                if (pass_reg == P_OVL && ovl)
                    ovl_reg <= 1'b1;
            end
            S_END:
            begin
                if (pass_reg == P_COV && sum_reg != np_reg)
                    st_reg <= (cmd_reg == CMD_UNMAP) ? STATUS_INVAL : STATUS_NOMEM;
                if (pass_reg == P_OVL && ovl_reg)
                    st_reg <= STATUS_INVAL;
            end
            S_INS:
            begin
                if (free_any)
                    start_res_reg <= ADDR_BITS'(sp_reg) << PAGE_SHIFT;
                else
                    st_reg <= STATUS_NOMEM;
            end
            default: ;
        endcase

        if (out_load)
        begin
            out_status_reg <= st_reg;
            out_start_reg  <= start_res_reg;
            out_hit_reg    <= hit_res_reg;
            out_slot_reg   <= slot_res_reg;
            out_prot_reg   <= prot_res_reg;
            out_backed_reg <= backed_res_reg;
            out_handle_reg <= handle_res_reg;
            out_pfo_reg    <= pfo_res_reg;
        end
    end

    assign response.valid            = out_valid_reg;
    assign response.status           = out_status_reg;
    assign response.mapped_start     = out_start_reg;
    assign response.hit              = out_hit_reg;
    assign response.region_slot      = out_slot_reg;
    assign response.region_prot      = out_prot_reg;
    assign response.region_backed    = out_backed_reg;
    assign response.region_handle    = out_handle_reg;
    assign response.page_file_offset = out_pfo_reg;

endmodule

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrt_pkg::*;

    localparam int SLOTS = DEF_TABLE_SLOTS;
    localparam int PSHIFT = DEF_PAGE_SHIFT;
    localparam longint unsigned PAGE_LOW = (64'd1 << PSHIFT) - 1;
    localparam longint unsigned AMASK = 64'hFFFF_FFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic [CMD_BITS-1:0]     cmd;
        logic [ADDR_BITS-1:0]    address;
        logic [LEN_BITS-1:0]     length;
        logic [PROT_IN_BITS-1:0] prot;
        logic                    shared_m;
        logic                    private_m;
        logic                    fixed_m;
        logic                    backed;
        logic [HANDLE_BITS-1:0]  handle;
        logic [ADDR_BITS-1:0]    offset;
    } region_cmd_t;

    typedef struct {
        logic [STATUS_BITS-1:0]   status;
        logic [ADDR_BITS-1:0]     mapped_start;
        logic                     hit;
        logic [SLOT_OUT_BITS-1:0] slot;
        logic [PROT_BITS-1:0]     prot;
        logic                     backed;
        logic [HANDLE_BITS-1:0]   handle;
        logic [ADDR_BITS-1:0]     page_offset;
    } region_rsp_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [ADDR_BITS-1:0] cfg_data;

    mrt_req_if request ();
    mrt_rsp_if response ();

    mapped_region_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request.sink),
        .response  (response.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    region_cmd_t pending_cmds[$];
    region_rsp_t expected_rsps[$];
    int errors;
    int stall_cycles;
    bit calm;
    logic req_fire;

    bit              rv[SLOTS];
    longint unsigned rstart[SLOTS];
    longint unsigned rcount[SLOTS];
    longint unsigned roff[SLOTS];
    bit [2:0]        rprot[SLOTS];
    bit              rshared[SLOTS];
    bit              rbacked[SLOTS];
    bit [15:0]       rhandle[SLOTS];
    longint unsigned map_base;
    longint unsigned user_top;
    longint unsigned cursor;

    function automatic int find_region(longint unsigned pg);
        for (int s = 0; s < SLOTS; s++)
            if (rv[s] && pg >= rstart[s] && pg < rstart[s] + rcount[s])
                return s;
        return -1;
    endfunction

    function automatic int free_region();
        for (int s = 0; s < SLOTS; s++)
            if (!rv[s])
                return s;
        return -1;
    endfunction

    function automatic bit range_covered(longint unsigned ap, longint unsigned ep);
        longint unsigned p;
        int s;
        p = ap;
        for (int k = 0; k <= SLOTS; k++)
        begin
            if (p >= ep)
                return 1;
            s = find_region(p);
            if (s < 0)
                return 0;
            p = rstart[s] + rcount[s];
        end
        return p >= ep;
    endfunction

    function automatic longint unsigned page_count(longint unsigned len);
        return (len >> PSHIFT) + (((len & PAGE_LOW) != 0) ? 1 : 0);
    endfunction

    function automatic void cut_pages(longint unsigned sp, longint unsigned ep);
        longint unsigned rs, re, us, ue;
        int t;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!rv[i])
                continue;
            rs = rstart[i];
            re = rs + rcount[i];
            if (sp >= re || ep <= rs)
                continue;
            us = (sp > rs) ? sp : rs;
            ue = (ep < re) ? ep : re;
            if (us == rs && ue == re)
                rv[i] = 0;
            else if (us == rs)
            begin
                roff[i] = (roff[i] + ((ue - rs) << PSHIFT)) & AMASK;
                rstart[i] = ue;
                rcount[i] = re - ue;
            end
            else if (ue == re)
                rcount[i] = us - rs;
            else
            begin
                t = free_region();
                if (t >= 0)
                begin
                    rstart[t] = ue;
                    rcount[t] = re - ue;
                    rprot[t] = rprot[i];
                    rshared[t] = rshared[i];
                    rbacked[t] = rbacked[i];
                    rhandle[t] = rhandle[i];
                    roff[t] = (roff[i] + ((ue - rs) << PSHIFT)) & AMASK;
                    rv[t] = 1;
                end
                rcount[i] = us - rs;
            end
        end
    endfunction

    function automatic logic [STATUS_BITS-1:0] map_region(region_cmd_t c,
                                                          output logic [ADDR_BITS-1:0] start);
        longint unsigned np, sp, ep;
        int s;
        start = '0;
        if (c.length == 0 || c.prot[7:3] != 0 || c.shared_m == c.private_m)
            return STATUS_INVAL;
        if ((c.offset & PAGE_LOW) != 0 || (c.fixed_m && (c.address & PAGE_LOW) != 0))
            return STATUS_INVAL;
        np = page_count(c.length);
        sp = (c.fixed_m ? longint'(c.address) : cursor) >> PSHIFT;
        ep = sp + np;
        if (ep > (user_top >> PSHIFT))
            return STATUS_NOMEM;
        if (!c.fixed_m)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (rv[i] && sp < rstart[i] + rcount[i] && ep > rstart[i])
                    return STATUS_INVAL;
        end
        else
            cut_pages(sp, ep);
        s = free_region();
        if (s < 0)
            return STATUS_NOMEM;
        rstart[s] = sp;
        rcount[s] = np;
        rprot[s] = c.prot[2:0];
        rshared[s] = c.shared_m;
        rbacked[s] = c.backed;
        rhandle[s] = c.backed ? c.handle : 16'd0;
        roff[s] = c.offset;
        rv[s] = 1;
        if ((ep << PSHIFT) > cursor)
            cursor = (ep << PSHIFT) & AMASK;
        start = ADDR_BITS'((sp << PSHIFT) & AMASK);
        return STATUS_OK;
    endfunction

    function automatic region_rsp_t predict_region(region_cmd_t c);
        region_rsp_t r;
        longint unsigned ap, ep;
        int s;
        r = '{default: '0};
        ap = longint'(c.address) >> PSHIFT;
        case (c.cmd)
            CMD_LOOKUP:
            begin
                s = find_region(ap);
                if (s >= 0)
                begin
                    r.hit = 1;
                    r.slot = SLOT_OUT_BITS'(s);
                    r.prot = rprot[s];
                    r.backed = rbacked[s];
                    r.handle = rhandle[s];
                    r.page_offset = ADDR_BITS'((roff[s] + ((ap - rstart[s]) << PSHIFT))
                                               & AMASK);
                end
            end
            CMD_MAP:
                r.status = map_region(c, r.mapped_start);
            CMD_UNMAP:
            begin
                ep = ap + page_count(c.length);
                if ((c.address & PAGE_LOW) != 0 || c.length == 0 || !range_covered(ap, ep))
                    r.status = STATUS_INVAL;
                else
                    cut_pages(ap, ep);
            end
            CMD_PROTECT:
            begin
                ep = ap + page_count(c.length);
                if (c.prot[7:3] != 0 || (c.address & PAGE_LOW) != 0 || c.length == 0)
                    r.status = STATUS_INVAL;
                else if (!range_covered(ap, ep))
                    r.status = STATUS_NOMEM;
                else
                    for (int i = 0; i < SLOTS; i++)
                        if (rv[i] && ap < rstart[i] + rcount[i] && ep > rstart[i])
                            rprot[i] = c.prot[2:0];
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    rv[i] = 0;
                cursor = map_base;
            end
            default:
                r.status = STATUS_INVAL;
        endcase
        return r;
    endfunction

    function automatic region_cmd_t region_cmd(logic [2:0] cmd, logic [47:0] address,
                                               logic [47:0] length, logic [7:0] prot,
                                               logic shared_m, logic fixed_m, logic backed,
                                               logic [15:0] handle, logic [47:0] offset);
        region_cmd_t c;
        c.cmd = cmd;
        c.address = address;
        c.length = length;
        c.prot = prot;
        c.shared_m = shared_m;
        c.private_m = !shared_m;
        c.fixed_m = fixed_m;
        c.backed = backed;
        c.handle = handle;
        c.offset = offset;
        return c;
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic region_cmd_t random_cmd();
        region_cmd_t c;
        int pick;
        c.address = rand48();
        c.length = rand48();
        c.prot = 8'($urandom);
        c.shared_m = 1'($urandom);
        c.private_m = 1'($urandom);
        c.fixed_m = 1'($urandom);
        c.backed = 1'($urandom);
        c.handle = 16'($urandom);
        c.offset = rand48();
        c.cmd = 3'($urandom);
        if ($urandom_range(99) < 8)
            return c;
        pick = $urandom_range(99);
        if (pick < 36)
            c.cmd = CMD_MAP;
        else if (pick < 61)
            c.cmd = CMD_LOOKUP;
        else if (pick < 77)
            c.cmd = CMD_UNMAP;
        else if (pick < 94)
            c.cmd = CMD_PROTECT;
        else if (pick < 97)
            c.cmd = CMD_CLEAR;
        else
            c.cmd = 3'($urandom_range(5, 7));
        c.address = 48'(((map_base & ~PAGE_LOW) + $urandom_range(0, 47) * 4096) & AMASK);
        if ($urandom_range(99) < 4 || c.cmd == CMD_LOOKUP)
            c.address[11:0] = 12'($urandom);
        c.length = 48'($urandom_range(1, 6) * 4096);
        if ($urandom_range(99) < 10)
            c.length = c.length - 48'($urandom_range(0, 4095));
        if ($urandom_range(99) < 2)
            c.length = 0;
        c.prot = ($urandom_range(99) < 5) ? 8'($urandom) : 8'($urandom_range(7));
        if ($urandom_range(99) < 92)
            c.private_m = !c.shared_m;
        c.fixed_m = $urandom_range(99) < 40;
        c.offset[11:0] = ($urandom_range(99) < 5) ? 12'($urandom) : 12'd0;
        return c;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h, expected %0h", field, got, want);
        errors++;
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [47:0] value);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 0;
        if (idx == CFG_MAP_BASE)
            map_base = value;
        else
            user_top = value;
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || request.valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always #5 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_fire <= 0;
        else
            req_fire <= request.valid && request.ready;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!request.valid || req_fire)
            begin
                if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 22))
                begin
                    request.cmd <= pending_cmds[0].cmd;
                    request.address <= pending_cmds[0].address;
                    request.length <= pending_cmds[0].length;
                    request.prot_bits <= pending_cmds[0].prot;
                    request.shared_map <= pending_cmds[0].shared_m;
                    request.private_map <= pending_cmds[0].private_m;
                    request.fixed_map <= pending_cmds[0].fixed_m;
                    request.file_backed <= pending_cmds[0].backed;
                    request.backing_handle <= pending_cmds[0].handle;
                    request.file_offset <= pending_cmds[0].offset;
                    request.valid <= 1;
                    void'(pending_cmds.pop_front());
                end
                else
                    request.valid <= 0;
            end
            response.ready <= calm || $urandom_range(99) >= 22;
        end
    end

    always @(posedge clk)
    begin
        region_cmd_t c;
        region_rsp_t e;
        if (rst_n)
        begin
            if (request.valid && request.ready)
            begin
                c.cmd = request.cmd;
                c.address = request.address;
                c.length = request.length;
                c.prot = request.prot_bits;
                c.shared_m = request.shared_map;
                c.private_m = request.private_map;
                c.fixed_m = request.fixed_map;
                c.backed = request.file_backed;
                c.handle = request.backing_handle;
                c.offset = request.file_offset;
                expected_rsps.push_back(predict_region(c));
            end
            if (response.valid && response.ready)
            begin
                if (expected_rsps.size() == 0)
                    report("unexpected response status", response.status, 0);
                else
                begin
                    e = expected_rsps.pop_front();
                    if (response.status !== e.status)
                        report("status", response.status, e.status);
                    if (response.mapped_start !== e.mapped_start)
                        report("mapped_start", response.mapped_start, e.mapped_start);
                    if (response.hit !== e.hit)
                        report("hit", response.hit, e.hit);
                    if (response.region_slot !== e.slot)
                        report("region_slot", response.region_slot, e.slot);
                    if (response.region_prot !== e.prot)
                        report("region_prot", response.region_prot, e.prot);
                    if (response.region_backed !== e.backed)
                        report("region_backed", response.region_backed, e.backed);
                    if (response.region_handle !== e.handle)
                        report("region_handle", response.region_handle, e.handle);
                    if (response.page_file_offset !== e.page_offset)
                        report("page_file_offset", response.page_file_offset, e.page_offset);
                end
            end
            if ((request.valid && request.ready) || (response.valid && response.ready) ||
                (pending_cmds.size() == 0 && !request.valid && expected_rsps.size() == 0))
                stall_cycles = 0;
            else if (++stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [47:0] base_cfg[4];
        logic [47:0] top_cfg[4];
        logic [47:0] b;
        base_cfg = '{48'h0000_1000_0000, 48'h0, 48'hFFFF_FFF0_0000, 48'h7000};
        top_cfg = '{48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h2_0000};
        clk = 0;
        errors = 0;
        stall_cycles = 0;
        calm = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        request.valid = 0;
        request.cmd = '0;
        request.address = '0;
        request.length = '0;
        request.prot_bits = '0;
        request.shared_map = 0;
        request.private_map = 0;
        request.fixed_map = 0;
        request.file_backed = 0;
        request.backing_handle = '0;
        request.file_offset = '0;
        response.ready = 0;
        for (int i = 0; i < SLOTS; i++)
            rv[i] = 0;
        map_base = MAP_BASE_RESET;
        user_top = USER_TOP_RESET;
        cursor = map_base;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_MAP_BASE, base_cfg[ph]);
            write_reg(CFG_USER_TOP, top_cfg[ph]);
            calm = (ph == 1);
            if (ph == 0)
            begin
                b = map_base;
                pending_cmds.push_back(region_cmd(CMD_LOOKUP, b, 0, 0, 0, 0, 0, 0, 0));
                pending_cmds.push_back(region_cmd(CMD_MAP, 0, 48'h3000, 3, 0, 0, 1,
                                                  16'hABCD, 48'h5000));
                pending_cmds.push_back(region_cmd(CMD_LOOKUP, b + 48'h1234, 0, 0, 0, 0,
                                                  0, 0, 0));
                pending_cmds.push_back(region_cmd(CMD_MAP, 0, 0, 3, 0, 0, 1, 1, 0));
                pending_cmds.push_back(region_cmd(CMD_MAP, 0, 48'h1000, 8, 0, 0, 1, 1, 0));
                pending_cmds.push_back(region_cmd(CMD_MAP, 0, 48'h1000, 1, 1, 0, 1, 1, 0));
                pending_cmds[$].private_m = 1;
                pending_cmds.push_back(region_cmd(CMD_MAP, 0, 48'h1000, 1, 0, 0, 1, 1, 0));
                pending_cmds[$].private_m = 0;
                pending_cmds.push_back(region_cmd(CMD_MAP, 0, 48'h1000, 1, 0, 0, 1, 1,
                                                  48'h10));
                pending_cmds.push_back(region_cmd(CMD_MAP, b + 48'h8, 48'h1000, 1, 0, 1,
                                                  1, 1, 0));
                pending_cmds.push_back(region_cmd(CMD_MAP, 0, 48'hFFFF_FFFF_FFFF, 1, 0, 0,
                                                  1, 1, 0));
                pending_cmds.push_back(region_cmd(CMD_MAP, 48'h123, 48'h1001, 5, 1, 0, 0,
                                                  16'hFFFF, 48'h7000));
                pending_cmds.push_back(region_cmd(CMD_MAP, b + 48'h1000, 48'h1000, 7, 0,
                                                  1, 1, 16'h0001, 48'h9000));
                pending_cmds.push_back(region_cmd(CMD_MAP, b + 48'h3000, 48'h1000, 2, 0,
                                                  1, 1, 16'h0002, 48'hA000));
                pending_cmds.push_back(region_cmd(CMD_LOOKUP, b + 48'h4FFF, 0, 0, 0, 0,
                                                  0, 0, 0));
                pending_cmds.push_back(region_cmd(CMD_UNMAP, b + 48'h10000, 48'h1000, 0,
                                                  0, 0, 0, 0, 0));
                pending_cmds.push_back(region_cmd(CMD_UNMAP, b + 48'h4, 48'h1000, 0, 0,
                                                  0, 0, 0, 0));
                pending_cmds.push_back(region_cmd(CMD_UNMAP, b, 0, 0, 0, 0, 0, 0, 0));
                pending_cmds.push_back(region_cmd(CMD_PROTECT, b, 48'h1000, 8'hF0, 0, 0,
                                                  0, 0, 0));
                pending_cmds.push_back(region_cmd(CMD_PROTECT, b, 48'h10000, 1, 0, 0, 0,
                                                  0, 0));
                pending_cmds.push_back(region_cmd(CMD_PROTECT, b, 48'h5000, 7, 0, 0, 0,
                                                  0, 0));
                pending_cmds.push_back(region_cmd(CMD_UNMAP, b + 48'h1000, 48'h2800, 0,
                                                  0, 0, 0, 0, 0));
                pending_cmds.push_back(region_cmd(CMD_LOOKUP, b + 48'h3000, 0, 0, 0, 0,
                                                  0, 0, 0));
                pending_cmds.push_back(region_cmd(3'd5, b, 48'h1000, 1, 0, 0, 0, 0, 0));
                pending_cmds.push_back(region_cmd(3'd7, b, 48'h1000, 1, 0, 0, 0, 0, 0));
                pending_cmds.push_back(region_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
                pending_cmds.push_back(region_cmd(CMD_LOOKUP, b, 0, 0, 0, 0, 0, 0, 0));
            end
            for (int n = 0; n < 175; n++)
                pending_cmds.push_back(random_cmd());
            wait_idle();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

[mapped_region_table.f]
rtl/mrt_pkg.sv
rtl/mrt_if.sv
rtl/mrt_ram.sv
rtl/mapped_region_table.sv
test/tb.sv
